// ===== hw/rtl/fske_pkg.sv =====
// ----------------------------------------------------------------------------
// fske_pkg: shared types and constants of the four-state kinetics Euler step
// Widths, register indexes, request and sequencer codes, and the saturation and extension helpers.
// ----------------------------------------------------------------------------
package fske_pkg;

   localparam int OCC_W     = 32;           // Q16.16 occupancies, rates, stimulus
   localparam int OPR_W     = OCC_W + 1;    // multiplier operand, holds unsigned T
   localparam int PROD_W    = 2 * OPR_W;    // full product of the shared multiplier
   localparam int FRAC_W    = 16;           // fraction bits of Q16.16
   localparam int FLOW_W    = 2 * OCC_W - FRAC_W;   // product of two Q16.16 values
   localparam int ACC_W     = FLOW_W + 2;           // sum of up to four flows
   localparam int DELTA_W   = PROD_W - OCC_W;       // T * d dropped by 32 bits
   localparam int NUM_REGS  = 8;
   localparam int REG_IDX_W = $clog2(NUM_REGS);
   localparam int CSR_IDX_W = REG_IDX_W + 1;

   // Configuration register indexes.
   localparam logic [REG_IDX_W-1:0] REG_RATE_A_GAIN = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_RATE_B      = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_RATE_C      = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_RATE_D      = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_RATE_E_GAIN = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_RATE_E_BASE = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_RATE_A_BASE = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_SAMPLE_TIME = 3'd7;

   localparam logic [OCC_W-1:0] SAMPLE_TIME_RESET = 32'd42949673;

   // Request kinds.
   localparam logic REQ_STEP = 1'b0;
   localparam logic REQ_LOAD = 1'b1;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // Multiplier slots of one Euler step; rate and flow products are summed into registers that later slots read.
   localparam logic [3:0] SL_RA   = 4'd0;
   localparam logic [3:0] SL_RE   = 4'd1;
   localparam logic [3:0] SL_FA   = 4'd2;
   localparam logic [3:0] SL_FB   = 4'd3;
   localparam logic [3:0] SL_FC   = 4'd4;
   localparam logic [3:0] SL_FD   = 4'd5;
   localparam logic [3:0] SL_FE   = 4'd6;
   localparam logic [3:0] SL_X0   = 4'd7;
   localparam logic [3:0] SL_X1   = 4'd8;
   localparam logic [3:0] SL_X2   = 4'd9;
   localparam logic [3:0] SL_X3   = 4'd10;
   localparam logic [3:0] SL_LAST = 4'd11;

   typedef struct packed {
      logic [OPR_W-1:0] a;
      logic [OPR_W-1:0] b;
   } mul_op_type;

   // Clamp a wide signed sum to the signed 32-bit range.
   function automatic logic [OCC_W-1:0] sat_occ(input logic [ACC_W-1:0] v);
      logic [OCC_W-1:0] r;
      if (v[ACC_W-1:OCC_W-1] == {(ACC_W-OCC_W+1){v[ACC_W-1]}}) begin
         r = v[OCC_W-1:0];
      end else if (v[ACC_W-1]) begin
         r = {1'b1, {(OCC_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(OCC_W-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic [ACC_W-1:0] sext_occ(input logic [OCC_W-1:0] v);
      return {{(ACC_W-OCC_W){v[OCC_W-1]}}, v};
   endfunction

   function automatic logic [OPR_W-1:0] opr_s(input logic [OCC_W-1:0] v);
      return {v[OCC_W-1], v};
   endfunction

endpackage

// ===== hw/rtl/fske_ifs.sv =====
// ----------------------------------------------------------------------------
// fske_ifs: channel interfaces of the four-state kinetics Euler step
// Request, response and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface fske_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] stimulus;
   logic [31:0] load_s0;
   logic [31:0] load_s1;
   logic [31:0] load_s2;
   logic [31:0] load_s3;

   modport source (output valid, req_type, stimulus, load_s0, load_s1, load_s2, load_s3,
                   input ready);
   modport sink (input valid, req_type, stimulus, load_s0, load_s1, load_s2, load_s3,
                 output ready);
endinterface

interface fske_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] occ0;
   logic [31:0] occ1;
   logic [31:0] occ2;
   logic [31:0] occ3;

   modport source (output valid, occ0, occ1, occ2, occ3, input ready);
   modport sink (input valid, occ0, occ1, occ2, occ3, output ready);
endinterface

interface fske_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/four_state_kinetics_euler_step_top.sv =====
// ----------------------------------------------------------------------------
// four_state_kinetics_euler_step_top: forward Euler step of a four-state model
// Keeps four Q16.16 occupancies and advances them one step per stimulus word.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one word per item. A load word (req_type = 1) replaces the
//   four occupancies; a step word (req_type = 0) advances them by one Euler step
//   with stimulus u. Every word returns one rsp_chan word with the new state.
//   csr_chan writes the eight rate and sample time registers; writes are always
//   taken, indexes above seven are dropped, and they belong in idle periods.
// Timing:
//   A step runs eleven products through one shared 33 x 33 multiplier, one per
//   cycle, with each saturating add in the cycle after its product. The response
//   is registered as the block leaves the completion state for idle, and only in
//   idle is the next word taken. A load skips the multiplier and goes straight to
//   the completion state.
// Reset:
//   reset clears the occupancies and rate registers, sets sample_time to about
//   0.01 s and empties the response register.
// Stall:
//   A finished result waits in the response register while rsp_chan.ready is
//   low; the next word may be accepted meanwhile and completes once it drains.
// ----------------------------------------------------------------------------
module four_state_kinetics_euler_step_top
   import fske_pkg::*;
(
   input logic       clock,
   input logic       reset,
   fske_req_if.sink  req_chan,
   fske_rsp_if.source rsp_chan,
   fske_csr_if.sink  csr_chan
);

   logic [OCC_W-1:0]  cfg_ff [NUM_REGS];
   logic [OCC_W-1:0]  cfg_in [NUM_REGS];
   logic [1:0]        state_ff, state_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [OCC_W-1:0]  u_ff, u_in;
   logic [OCC_W-1:0]  ra_ff, ra_in;
   logic [OCC_W-1:0]  re_ff, re_in;
   logic [ACC_W-1:0]  acc_ff [4];
   logic [ACC_W-1:0]  acc_in [4];
   logic [OCC_W-1:0]  occ_ff [4];
   logic [OCC_W-1:0]  occ_in [4];
   logic [OCC_W-1:0]  rsp_occ_ff [4];
   logic [OCC_W-1:0]  rsp_occ_in [4];
   logic              rsp_valid_ff, rsp_valid_in;

   mul_op_type        mul_op;
   logic [PROD_W-1:0] prod_ff;
   logic [3:0]        post_slot;
   logic [ACC_W-1:0]  flow;
   logic [ACC_W-1:0]  delta;
   logic              req_acc;

   fske_mul u_mul (
      .clock   (clock),
      .op      (mul_op),
      .prod_ff (prod_ff)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.occ0  = rsp_occ_ff[0];
   assign rsp_chan.occ1  = rsp_occ_ff[1];
   assign rsp_chan.occ2  = rsp_occ_ff[2];
   assign rsp_chan.occ3  = rsp_occ_ff[3];

   // The product in prod_ff belongs to the slot issued in the previous cycle.
   assign post_slot = cnt_ff - 4'd1;
   assign flow      = {{(ACC_W-FLOW_W){prod_ff[2*OCC_W-1]}}, prod_ff[2*OCC_W-1:FRAC_W]};
   assign delta     = {{(ACC_W-DELTA_W){prod_ff[PROD_W-1]}}, prod_ff[PROD_W-1:OCC_W]};

   always_comb begin
      mul_op.a = '0;
      mul_op.b = '0;
      case (cnt_ff)
         SL_RA: begin
            mul_op.a = opr_s(cfg_ff[REG_RATE_A_GAIN]);
            mul_op.b = opr_s(u_ff);
         end
         SL_RE: begin
            mul_op.a = opr_s(cfg_ff[REG_RATE_E_GAIN]);
            mul_op.b = opr_s(u_ff);
         end
         SL_FA: begin
            mul_op.a = opr_s(ra_ff);
            mul_op.b = opr_s(occ_ff[0]);
         end
         SL_FB: begin
            mul_op.a = opr_s(cfg_ff[REG_RATE_B]);
            mul_op.b = opr_s(occ_ff[1]);
         end
         SL_FC: begin
            mul_op.a = opr_s(cfg_ff[REG_RATE_C]);
            mul_op.b = opr_s(occ_ff[2]);
         end
         SL_FD: begin
            mul_op.a = opr_s(cfg_ff[REG_RATE_D]);
            mul_op.b = opr_s(occ_ff[2]);
         end
         SL_FE: begin
            mul_op.a = opr_s(re_ff);
            mul_op.b = opr_s(occ_ff[3]);
         end
         SL_X0: begin
            mul_op.a = {1'b0, cfg_ff[REG_SAMPLE_TIME]};
            mul_op.b = opr_s(sat_occ(acc_ff[0]));
         end
         SL_X1: begin
            mul_op.a = {1'b0, cfg_ff[REG_SAMPLE_TIME]};
            mul_op.b = opr_s(sat_occ(acc_ff[1]));
         end
         SL_X2: begin
            mul_op.a = {1'b0, cfg_ff[REG_SAMPLE_TIME]};
            mul_op.b = opr_s(sat_occ(acc_ff[2]));
         end
         SL_X3: begin
            mul_op.a = {1'b0, cfg_ff[REG_SAMPLE_TIME]};
            mul_op.b = opr_s(sat_occ(acc_ff[3]));
         end
         default: begin
            mul_op.a = '0;
            mul_op.b = '0;
         end
      endcase
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid && csr_chan.ready && !csr_chan.index[CSR_IDX_W-1]) begin
         cfg_in[csr_chan.index[REG_IDX_W-1:0]] = csr_chan.data;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      u_in         = u_ff;
      ra_in        = ra_ff;
      re_in        = re_ff;
      acc_in       = acc_ff;
      occ_in       = occ_ff;
      rsp_occ_in   = rsp_occ_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_chan.req_type == REQ_LOAD) begin
                  occ_in[0] = req_chan.load_s0;
                  occ_in[1] = req_chan.load_s1;
                  occ_in[2] = req_chan.load_s2;
                  occ_in[3] = req_chan.load_s3;
                  state_in  = ST_DONE;
               end else begin
                  u_in     = req_chan.stimulus;
                  acc_in   = '{default: '0};
                  cnt_in   = SL_RA;
                  state_in = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            cnt_in = cnt_ff + 4'd1;
            // Each flow leaves one state and enters another.
            case (post_slot)
               SL_RA: ra_in = sat_occ(flow + sext_occ(cfg_ff[REG_RATE_A_BASE]));
               SL_RE: re_in = sat_occ(flow + sext_occ(cfg_ff[REG_RATE_E_BASE]));
               SL_FA: begin
                  acc_in[0] = acc_ff[0] - flow;
                  acc_in[1] = acc_ff[1] + flow;
               end
               SL_FB: begin
                  acc_in[1] = acc_ff[1] - flow;
                  acc_in[2] = acc_ff[2] + flow;
               end
               SL_FC: begin
                  acc_in[2] = acc_ff[2] - flow;
                  acc_in[0] = acc_ff[0] + flow;
               end
               SL_FD: begin
                  acc_in[2] = acc_ff[2] - flow;
                  acc_in[3] = acc_ff[3] + flow;
               end
               SL_FE: begin
                  acc_in[3] = acc_ff[3] - flow;
                  acc_in[2] = acc_ff[2] + flow;
               end
               SL_X0: occ_in[0] = sat_occ(sext_occ(occ_ff[0]) + delta);
               SL_X1: occ_in[1] = sat_occ(sext_occ(occ_ff[1]) + delta);
               SL_X2: occ_in[2] = sat_occ(sext_occ(occ_ff[2]) + delta);
               SL_X3: occ_in[3] = sat_occ(sext_occ(occ_ff[3]) + delta);
               default: begin
               end
            endcase
            if (cnt_ff == SL_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_occ_in   = occ_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{REG_SAMPLE_TIME: SAMPLE_TIME_RESET, default: '0};
         state_ff     <= ST_IDLE;
         cnt_ff       <= SL_RA;
         occ_ff       <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff       <= u_in;
      ra_ff      <= ra_in;
      re_ff      <= re_in;
      acc_ff     <= acc_in;
      rsp_occ_ff <= rsp_occ_in;
   end

   // A step word starts the sequencer at its first multiplier slot.
   a_step_start: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_chan.req_type == REQ_STEP)
      |=> (state_ff == ST_CALC) && (cnt_ff == SL_RA))
      else $error("step did not start the sequencer at its first slot");

   // A load word lands in the state registers unchanged.
   a_load_state: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_chan.req_type == REQ_LOAD)
      |=> (occ_ff[0] == $past(req_chan.load_s0)) && (occ_ff[3] == $past(req_chan.load_s3)))
      else $error("load word did not reach the state registers");

   // A new response only comes out of the completion state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside the completion state");

   // The slot counter never runs past the last slot while computing.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC) |-> (cnt_ff <= SL_LAST))
      else $error("slot counter ran past the last slot");

endmodule

// ===== hw/rtl/fske_mul.sv =====
// ----------------------------------------------------------------------------
// fske_mul: shared signed multiplier
// One 33 x 33 signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module fske_mul
   import fske_pkg::*;
(
   input  logic              clock,
   input  mul_op_type        op,
   output logic [PROD_W-1:0] prod_ff
);

   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'($signed(op.a) * $signed(op.b));

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the four-state kinetics Euler step
// Drives load and step words with random gaps, stalls the response channel,
// reprograms the rate registers between phases and compares every response
// word against a fixed-point model of the Euler step kept in a scoreboard.
// ----------------------------------------------------------------------------
module tb_top
   import fske_pkg::*;
;

   localparam int IDLE_LIMIT  = 2000;
   localparam int DRAIN_WAIT  = 20;
   localparam int MAX_REPORTS = 10;
   localparam int RAND_PHASES = 6;
   localparam int PHASE_ITEMS = 84;

   localparam logic [OCC_W-1:0] Q_MAX = 32'h7fff_ffff;
   localparam logic [OCC_W-1:0] Q_MIN = 32'h8000_0000;
   localparam logic [OCC_W-1:0] Q_ONE = 32'h0001_0000;
   localparam logic [OCC_W-1:0] Q_NEG_ONE = 32'hffff_0000;
   localparam logic [OCC_W-1:0] Q_HALF = 32'h0000_8000;
   localparam logic [OCC_W-1:0] Q_QUARTER = 32'h0000_4000;
   localparam logic [OCC_W-1:0] T_MAX = 32'hffff_ffff;

   typedef logic [3:0][OCC_W-1:0] occ_vec_type;
   typedef logic [NUM_REGS-1:0][OCC_W-1:0] reg_set_type;

   typedef struct packed {
      logic             req_type;
      logic [OCC_W-1:0] stimulus;
      occ_vec_type      load_s;
   } req_word_type;

   // Model of the block: mirrors the registers and the occupancies, and
   // queues the state expected after every accepted request word.
   class occupancy_scoreboard;
      logic [OCC_W-1:0] rate_regs [NUM_REGS];
      occ_vec_type occ;
      occ_vec_type expected_q[$];
      int n_loads;
      int n_steps;
      int n_checked;
      int n_mismatch;

      function new();
         foreach (rate_regs[i]) rate_regs[i] = '0;
         rate_regs[REG_SAMPLE_TIME] = SAMPLE_TIME_RESET;
         occ = '0;
         n_loads = 0;
         n_steps = 0;
         n_checked = 0;
         n_mismatch = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [OCC_W-1:0] data);
         if (idx < NUM_REGS) rate_regs[idx[REG_IDX_W-1:0]] = data;
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint rate(int i);
         return $signed(rate_regs[i]);
      endfunction

      function void note_request(req_word_type w);
         longint u, t, ra, re, fa, fb, fc, fd, fe, nx;
         longint x[4];
         longint d[4];
         if (w.req_type == REQ_LOAD) begin
            occ = w.load_s;
            n_loads++;
         end else begin
            u = $signed(w.stimulus);
            for (int i = 0; i < 4; i++) x[i] = $signed(occ[i]);
            t = longint'({32'd0, rate_regs[REG_SAMPLE_TIME]});
            ra = clamp32(((rate(REG_RATE_A_GAIN) * u) >>> FRAC_W) + rate(REG_RATE_A_BASE));
            re = clamp32(((rate(REG_RATE_E_GAIN) * u) >>> FRAC_W) + rate(REG_RATE_E_BASE));
            fa = (ra * x[0]) >>> FRAC_W;
            fb = (rate(REG_RATE_B) * x[1]) >>> FRAC_W;
            fc = (rate(REG_RATE_C) * x[2]) >>> FRAC_W;
            fd = (rate(REG_RATE_D) * x[2]) >>> FRAC_W;
            fe = (re * x[3]) >>> FRAC_W;
            d[0] = clamp32(fc - fa);
            d[1] = clamp32(fa - fb);
            d[2] = clamp32(fb - fc - fd + fe);
            d[3] = clamp32(fd - fe);
            // T is Q0.32, so the product of T and a Q16.16 change drops 32 bits.
            for (int i = 0; i < 4; i++) begin
               nx = clamp32(x[i] + ((t * d[i]) >>> OCC_W));
               occ[i] = nx[OCC_W-1:0];
            end
            n_steps++;
         end
         expected_q.push_back(occ);
      endfunction

      function void check_response(occ_vec_type got);
         occ_vec_type want;
         if (expected_q.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS)
               $display("ERROR: response word %h with no request pending", got);
            return;
         end
         want = expected_q.pop_front();
         n_checked++;
         for (int i = 0; i < 4; i++) begin
            if (got[i] !== want[i]) begin
               n_mismatch++;
               if (n_mismatch <= MAX_REPORTS)
                  $display("ERROR: response %0d occ%0d expected %h actual %h",
                           n_checked, i, want[i], got[i]);
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   quiet_phase;
   int   idle_cycles;
   int   n_settings;

   fske_req_if req_chan ();
   fske_rsp_if rsp_chan ();
   fske_csr_if csr_chan ();

   occupancy_scoreboard sb = new();

   four_state_kinetics_euler_step_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_phase || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function logic [OCC_W-1:0] pick_extreme();
      case ($urandom_range(0, 3))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   function logic [OCC_W-1:0] pick_stimulus();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return pick_extreme();
      if (r < 3) return $urandom;
      return $urandom_range(0, 8 * Q_ONE) - 4 * Q_ONE;
   endfunction

   function logic [OCC_W-1:0] pick_occ();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return pick_extreme();
      if (r == 1) return $urandom;
      return $urandom_range(0, Q_ONE);
   endfunction

   function logic [OCC_W-1:0] pick_rate();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return pick_extreme();
      if (r == 1) return $urandom;
      if (r == 2) return '0;
      if (r == 3) return -$urandom_range(0, 20 * Q_ONE);
      return $urandom_range(0, 50 * Q_ONE);
   endfunction

   function logic [OCC_W-1:0] pick_sample_time();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return ($urandom_range(0, 1) != 0) ? T_MAX : '0;
      if (r == 1) return $urandom;
      return $urandom_range(0, 2 * SAMPLE_TIME_RESET);
   endfunction

   function reg_set_type rate_set(logic [OCC_W-1:0] p0, p1, p2, p3, p4, p5, p6, t);
      reg_set_type s;
      s[REG_RATE_A_GAIN] = p0;
      s[REG_RATE_B]      = p1;
      s[REG_RATE_C]      = p2;
      s[REG_RATE_D]      = p3;
      s[REG_RATE_E_GAIN] = p4;
      s[REG_RATE_E_BASE] = p5;
      s[REG_RATE_A_BASE] = p6;
      s[REG_SAMPLE_TIME] = t;
      return s;
   endfunction

   function req_word_type load_word(logic [OCC_W-1:0] s0, s1, s2, s3);
      req_word_type w;
      w.req_type = REQ_LOAD;
      w.stimulus = $urandom;
      w.load_s = {s3, s2, s1, s0};
      return w;
   endfunction

   function req_word_type step_word(logic [OCC_W-1:0] u);
      req_word_type w;
      w.req_type = REQ_STEP;
      w.stimulus = u;
      for (int i = 0; i < 4; i++) w.load_s[i] = $urandom;
      return w;
   endfunction

   function req_word_type random_word();
      req_word_type w;
      w.req_type = ($urandom_range(0, 99) < 10) ? REQ_LOAD : REQ_STEP;
      w.stimulus = pick_stimulus();
      for (int i = 0; i < 4; i++) w.load_s[i] = pick_occ();
      return w;
   endfunction

   // All tasks start and end just after a falling edge.
   task automatic send_word(req_word_type w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid    = 1'b1;
      req_chan.req_type = w.req_type;
      req_chan.stimulus = w.stimulus;
      req_chan.load_s0  = w.load_s[0];
      req_chan.load_s1  = w.load_s[1];
      req_chan.load_s2  = w.load_s[2];
      req_chan.load_s3  = w.load_s[3];
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(w);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [OCC_W-1:0] data);
      csr_chan.valid = 1'b1;
      csr_chan.index = idx;
      csr_chan.data  = data;
      do @(posedge clock); while (!csr_chan.ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   // Registers change only with the request channel quiet and nothing in flight.
   task automatic program_regs(reg_set_type s);
      req_chan.valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (2) @(negedge clock);
      for (int i = 0; i < NUM_REGS; i++) write_csr(CSR_IDX_W'(i), s[i]);
      // Indexes past the last register must leave every register alone.
      if ($urandom_range(0, 1) != 0)
         write_csr(CSR_IDX_W'($urandom_range(NUM_REGS, 2 ** CSR_IDX_W - 1)), $urandom);
      n_settings++;
   endtask

   // Response side: random back-pressure, every accepted word is checked.
   initial begin
      int stall_left;
      rsp_chan.ready = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready)
            sb.check_response({rsp_chan.occ3, rsp_chan.occ2, rsp_chan.occ1, rsp_chan.occ0});
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_chan.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready = 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("ERROR: no handshake for %0d cycles", IDLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      idle_cycles = 0;
      n_settings = 0;
      quiet_phase = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.req_type = REQ_STEP;
      req_chan.stimulus = '0;
      req_chan.load_s0 = '0;
      req_chan.load_s1 = '0;
      req_chan.load_s2 = '0;
      req_chan.load_s3 = '0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset registers: all rates zero, so steps leave the state alone.
      send_word(step_word('0));
      send_word(load_word(Q_MAX, Q_MIN, '0, '1));
      send_word(step_word(Q_MAX));

      // A plausible setting with the usual sample time.
      program_regs(rate_set(2 * Q_ONE, Q_ONE + Q_HALF, Q_HALF, Q_QUARTER, 3 * Q_ONE,
                            32'h0000_1999, 32'h0000_0ccc, SAMPLE_TIME_RESET));
      send_word(load_word(Q_ONE, '0, '0, '0));
      send_word(step_word(Q_ONE));
      send_word(step_word(Q_NEG_ONE));
      send_word(step_word(Q_MAX));
      send_word(step_word(Q_MIN));
      send_word(step_word(Q_HALF));
      send_word(load_word(Q_QUARTER, Q_QUARTER, Q_QUARTER, Q_QUARTER));
      send_word(step_word('0));

      // Largest rates and sample time push the rate and change sums into saturation.
      program_regs(rate_set(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, T_MAX));
      send_word(load_word(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
      send_word(step_word(Q_MAX));
      send_word(load_word(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
      send_word(step_word(Q_MIN));
      send_word(step_word('0));

      // Most negative rates are taken as they are.
      program_regs(rate_set(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, T_MAX));
      send_word(load_word(Q_MAX, Q_MIN, Q_MAX, Q_MIN));
      send_word(step_word(Q_MAX));
      send_word(step_word(Q_MIN));

      // A zero sample time freezes the state whatever the rates are.
      program_regs(rate_set($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, '0));
      send_word(load_word($urandom, $urandom, $urandom, $urandom));
      send_word(step_word($urandom));

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         quiet_phase = (ph == 2);
         program_regs(rate_set(pick_rate(), pick_rate(), pick_rate(), pick_rate(),
                               pick_rate(), pick_rate(), pick_rate(), pick_sample_time()));
         send_word(load_word(pick_occ(), pick_occ(), pick_occ(), pick_occ()));
         for (int k = 0; k < PHASE_ITEMS; k++) send_word(random_word());
      end
      quiet_phase = 1'b0;
      req_chan.valid = 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Ran %0d load and %0d step words under %0d register settings.",
               sb.n_loads, sb.n_steps, n_settings);
      $display("Checked %0d response words, %0d field mismatches.",
               sb.n_checked, sb.n_mismatch);
      if (sb.n_mismatch == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         if (sb.pending() != 0)
            $display("ERROR: %0d expected responses never arrived", sb.pending());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
